@@ rtl/core/id_range_prefetch_dispenser_macros.svh @@
// Assertion macros shared by the ID range prefetch dispenser RTL.
`ifndef ID_RANGE_PREFETCH_DISPENSER_MACROS_SVH
`define ID_RANGE_PREFETCH_DISPENSER_MACROS_SVH

// The condition must hold at every clock edge out of reset.
`define IDRPD_ASSERT_ALWAYS(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("idrpd assertion failed");

// The consequent must hold in the same cycle as the antecedent.
`define IDRPD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("idrpd assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define IDRPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("idrpd assertion failed");

`endif

@@ rtl/core/idrpd_pkg.sv @@
// Types, constants and codes of the ID range prefetch dispenser.
package idrpd_pkg;

  localparam int QUEUE_DEPTH = 8;
  localparam int MAX_RESULTS = 8;

  localparam int QIDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int RIDX_W = (MAX_RESULTS > 1) ? $clog2(MAX_RESULTS) : 1;
  localparam int RCNT_W = $clog2(MAX_RESULTS + 1);

  localparam int ID_W    = 63;
  localparam int LEN_W   = 24;
  localparam int VOL_W   = 32;
  localparam int ENTRY_W = ID_W + LEN_W;

  localparam logic [LEN_W-1:0] PREFETCH_RESET  = 24'd4096;
  localparam logic [LEN_W-1:0] LOW_WATER_RESET = 24'd1024;

  typedef enum logic [1:0] {
    OP_REQUEST = 2'd0,
    OP_REFILL  = 2'd1,
    OP_FAIL    = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_WAIT  = 2'd1,
    STATUS_ERROR = 2'd2,
    STATUS_FULL  = 2'd3
  } status_t;

  typedef enum logic {
    CFG_PREFETCH_SIZE = 1'b0,
    CFG_LOW_WATER     = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_CALC,
    S_FINISH,
    S_DRAIN
  } seq_state_t;

endpackage

@@ rtl/core/idrpd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module idrpd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/core/id_range_prefetch_dispenser.sv @@
// Top level of the ID range prefetch dispenser: range queue, sequencer and result buffer.
//
// The block holds up to QUEUE_DEPTH prefetched ID ranges in a small RAM and
// serves requests from the head range onward. An input transaction is taken
// only while the sequencer is idle. A request or a resumed request has an
// accept step, a queue RAM read then the shared take/update step for each
// granted piece, a finish step and the delivery of its results, one per
// granted piece or one for a status-only answer; the registered read of the
// single queue RAM port is why each piece needs its own read step. A request
// while another one waits and a failure with a pending request go from the
// accept step straight to delivering one status-only result. A refill without
// a pending request, a failure without a pending request and ignored
// transactions end in the accept step and give no result.
// Up to MAX_RESULTS grant pieces come from one input; every result of an input
// carries the same status, and a fetch launch is flagged on the last one.
`include "id_range_prefetch_dispenser_macros.svh"

module id_range_prefetch_dispenser
  import idrpd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [LEN_W-1:0] cfg_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       in_operation,
  input  logic [LEN_W-1:0] in_request_length,
  input  logic [ID_W-1:0]  in_range_start,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [ID_W-1:0]  out_grant_start,
  output logic [LEN_W-1:0] out_grant_length,
  output logic             out_last_piece,
  output logic             out_fetch_launch,
  output logic [LEN_W-1:0] out_fetch_length,
  output logic [1:0]       out_status
);

  seq_state_t state_r, state_nxt;

  logic [LEN_W-1:0]  prefetch_size_r;
  logic [LEN_W-1:0]  low_water_r;
  logic [QIDX_W-1:0] head_r, head_nxt;
  logic [QCNT_W-1:0] entry_count_r, entry_count_nxt;
  logic [VOL_W-1:0]  held_volume_r, held_volume_nxt;
  logic              fetch_busy_r, fetch_busy_nxt;
  logic [LEN_W-1:0]  outstanding_r, outstanding_nxt;
  logic [LEN_W-1:0]  pending_r, pending_nxt;
  logic [LEN_W-1:0]  owed_r, owed_nxt;
  logic [RCNT_W-1:0] res_cnt_r, res_cnt_nxt;
  logic [RIDX_W-1:0] drain_idx_r, drain_idx_nxt;
  status_t           fin_status_r, fin_status_nxt;
  logic              fin_launch_r, fin_launch_nxt;
  logic [LEN_W-1:0]  fin_flen_r, fin_flen_nxt;

  logic [ID_W-1:0]   buf_start_r [MAX_RESULTS];
  logic [LEN_W-1:0]  buf_len_r   [MAX_RESULTS];
  logic              buf_we;
  logic [RIDX_W-1:0] buf_widx;
  logic [ID_W-1:0]   buf_wstart;
  logic [LEN_W-1:0]  buf_wlen;

  logic              out_valid_r;
  logic [ID_W-1:0]   out_grant_start_r;
  logic [LEN_W-1:0]  out_grant_length_r;
  logic              out_last_piece_r;
  logic              out_fetch_launch_r;
  logic [LEN_W-1:0]  out_fetch_length_r;
  status_t           out_status_r;

  logic               ram_we;
  logic [QIDX_W-1:0]  ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic               ram_re;
  logic [ENTRY_W-1:0] ram_rdata;

  logic              in_accept;
  logic              queue_full;
  logic              append_ok;
  logic [QCNT_W-1:0] refill_count;
  logic [QIDX_W:0]   tail_sum;
  logic [QIDX_W-1:0] tail_idx;
  logic [QIDX_W-1:0] head_inc;
  logic [ID_W-1:0]   rd_start;
  logic [LEN_W-1:0]  rd_len;
  logic [LEN_W-1:0]  take;
  logic [LEN_W-1:0]  rest_len;
  logic              pop;
  logic [LEN_W-1:0]  owed_left;
  logic [QCNT_W-1:0] count_left;
  logic [RCNT_W-1:0] res_cnt_inc;
  logic              serve_more;
  logic [LEN_W-1:0]  eff_prefetch;
  logic [LEN_W-1:0]  owed_fetch;
  logic              below_water;
  logic              out_free;
  logic              out_load;
  logic              is_last;

  idrpd_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (head_r),
    .rdata (ram_rdata)
  );

  assign in_accept    = in_valid && (state_r == S_IDLE);
  assign in_stall     = (state_r != S_IDLE);
  assign queue_full   = (entry_count_r >= QCNT_W'(QUEUE_DEPTH));
  assign append_ok    = fetch_busy_r && (outstanding_r != '0) && !queue_full;
  assign refill_count = append_ok ? entry_count_r + QCNT_W'(1) : entry_count_r;

  // Tail slot is head plus count, folded back once into the queue depth.
  assign tail_sum = {1'b0, head_r} + (QIDX_W + 1)'(entry_count_r);
  assign tail_idx = (tail_sum >= (QIDX_W + 1)'(QUEUE_DEPTH)) ?
                    QIDX_W'(tail_sum - (QIDX_W + 1)'(QUEUE_DEPTH)) :
                    QIDX_W'(tail_sum);
  assign head_inc = (head_r == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_r + QIDX_W'(1);

  // Shared take/update step on the head entry.
  assign rd_start    = ram_rdata[ENTRY_W-1:LEN_W];
  assign rd_len      = ram_rdata[LEN_W-1:0];
  assign take        = (rd_len < owed_r) ? rd_len : owed_r;
  assign rest_len    = rd_len - take;
  assign pop         = (rest_len == '0);
  assign owed_left   = owed_r - take;
  assign count_left  = pop ? entry_count_r - QCNT_W'(1) : entry_count_r;
  assign res_cnt_inc = res_cnt_r + RCNT_W'(1);
  assign serve_more  = (owed_left != '0) && (count_left != '0) &&
                       (res_cnt_inc < RCNT_W'(MAX_RESULTS));

  assign eff_prefetch = (prefetch_size_r == '0) ? LEN_W'(1) : prefetch_size_r;
  assign owed_fetch   = (owed_r > eff_prefetch) ? owed_r : eff_prefetch;
  assign below_water  = (held_volume_r < VOL_W'(low_water_r));

  assign out_free = !out_valid_r || !out_stall;
  assign out_load = (state_r == S_DRAIN) && out_free;
  assign is_last  = ((RCNT_W'(drain_idx_r) + RCNT_W'(1)) == res_cnt_r);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          case (in_operation)
            OP_REQUEST: begin
              if (pending_r != '0) begin
                state_nxt = S_DRAIN;
              end else if ((in_request_length != '0) && (entry_count_r != '0)) begin
                state_nxt = S_READ;
              end else begin
                state_nxt = S_FINISH;
              end
            end
            OP_REFILL: begin
              if (fetch_busy_r && (pending_r != '0)) begin
                state_nxt = (refill_count != '0) ? S_READ : S_FINISH;
              end
            end
            OP_FAIL: begin
              if (fetch_busy_r && (pending_r != '0)) begin
                state_nxt = S_DRAIN;
              end
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_READ:   state_nxt = S_CALC;
      S_CALC:   state_nxt = serve_more ? S_READ : S_FINISH;
      S_FINISH: state_nxt = S_DRAIN;
      S_DRAIN: begin
        if (out_load && is_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath and control outputs.
  always_comb begin
    head_nxt        = head_r;
    entry_count_nxt = entry_count_r;
    held_volume_nxt = held_volume_r;
    fetch_busy_nxt  = fetch_busy_r;
    outstanding_nxt = outstanding_r;
    pending_nxt     = pending_r;
    owed_nxt        = owed_r;
    res_cnt_nxt     = res_cnt_r;
    drain_idx_nxt   = drain_idx_r;
    fin_status_nxt  = fin_status_r;
    fin_launch_nxt  = fin_launch_r;
    fin_flen_nxt    = fin_flen_r;
    ram_we          = 1'b0;
    ram_waddr       = head_r;
    ram_wdata       = '0;
    ram_re          = 1'b0;
    buf_we          = 1'b0;
    buf_widx        = RIDX_W'(res_cnt_r);
    buf_wstart      = '0;
    buf_wlen        = '0;

    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          case (in_operation)
            OP_REQUEST: begin
              if (pending_r != '0) begin
                // A second request while one waits gets a status-only answer.
                buf_we         = 1'b1;
                buf_widx       = '0;
                res_cnt_nxt    = RCNT_W'(1);
                drain_idx_nxt  = '0;
                fin_status_nxt = STATUS_WAIT;
                fin_launch_nxt = 1'b0;
                fin_flen_nxt   = '0;
              end else begin
                owed_nxt    = in_request_length;
                res_cnt_nxt = '0;
              end
            end
            OP_REFILL: begin
              if (fetch_busy_r) begin
                fetch_busy_nxt  = 1'b0;
                outstanding_nxt = '0;
                if (append_ok) begin
                  ram_we          = 1'b1;
                  ram_waddr       = tail_idx;
                  ram_wdata       = {in_range_start, outstanding_r};
                  entry_count_nxt = entry_count_r + QCNT_W'(1);
                  held_volume_nxt = held_volume_r + VOL_W'(outstanding_r);
                end
                owed_nxt    = pending_r;
                res_cnt_nxt = '0;
              end
            end
            OP_FAIL: begin
              if (fetch_busy_r) begin
                fetch_busy_nxt  = 1'b0;
                outstanding_nxt = '0;
                if (pending_r != '0) begin
                  pending_nxt    = '0;
                  buf_we         = 1'b1;
                  buf_widx       = '0;
                  res_cnt_nxt    = RCNT_W'(1);
                  drain_idx_nxt  = '0;
                  fin_status_nxt = STATUS_ERROR;
                  fin_launch_nxt = 1'b0;
                  fin_flen_nxt   = '0;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_READ: begin
        ram_re = 1'b1;
      end
      S_CALC: begin
        ram_we          = 1'b1;
        ram_waddr       = head_r;
        ram_wdata       = {rd_start + ID_W'(take), rest_len};
        buf_we          = 1'b1;
        buf_wstart      = rd_start;
        buf_wlen        = take;
        res_cnt_nxt     = res_cnt_inc;
        held_volume_nxt = held_volume_r - VOL_W'(take);
        owed_nxt        = owed_left;
        entry_count_nxt = count_left;
        if (pop) begin
          head_nxt = head_inc;
        end
      end
      S_FINISH: begin
        fin_launch_nxt = 1'b0;
        fin_flen_nxt   = '0;
        fin_status_nxt = STATUS_DONE;
        drain_idx_nxt  = '0;
        if (owed_r != '0) begin
          if (fetch_busy_r) begin
            pending_nxt    = owed_r;
            fin_status_nxt = STATUS_WAIT;
          end else if (queue_full) begin
            pending_nxt    = '0;
            fin_status_nxt = STATUS_FULL;
          end else begin
            fin_launch_nxt  = 1'b1;
            fin_flen_nxt    = owed_fetch;
            fetch_busy_nxt  = 1'b1;
            outstanding_nxt = owed_fetch;
            pending_nxt     = owed_r;
            fin_status_nxt  = STATUS_WAIT;
          end
        end else begin
          pending_nxt = '0;
          if (!fetch_busy_r && below_water) begin
            if (queue_full) begin
              fin_status_nxt = STATUS_FULL;
            end else begin
              fin_launch_nxt  = 1'b1;
              fin_flen_nxt    = eff_prefetch;
              fetch_busy_nxt  = 1'b1;
              outstanding_nxt = eff_prefetch;
            end
          end
        end
        // Nothing granted: one status-only result stands in.
        if (res_cnt_r == '0) begin
          buf_we      = 1'b1;
          buf_widx    = '0;
          res_cnt_nxt = RCNT_W'(1);
        end
      end
      S_DRAIN: begin
        if (out_load) begin
          drain_idx_nxt = drain_idx_r + RIDX_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      prefetch_size_r <= PREFETCH_RESET;
      low_water_r     <= LOW_WATER_RESET;
      head_r          <= '0;
      entry_count_r   <= '0;
      held_volume_r   <= '0;
      fetch_busy_r    <= 1'b0;
      outstanding_r   <= '0;
      pending_r       <= '0;
      owed_r          <= '0;
      res_cnt_r       <= '0;
      drain_idx_r     <= '0;
      fin_status_r    <= STATUS_DONE;
      fin_launch_r    <= 1'b0;
      fin_flen_r      <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      head_r        <= head_nxt;
      entry_count_r <= entry_count_nxt;
      held_volume_r <= held_volume_nxt;
      fetch_busy_r  <= fetch_busy_nxt;
      outstanding_r <= outstanding_nxt;
      pending_r     <= pending_nxt;
      owed_r        <= owed_nxt;
      res_cnt_r     <= res_cnt_nxt;
      drain_idx_r   <= drain_idx_nxt;
      fin_status_r  <= fin_status_nxt;
      fin_launch_r  <= fin_launch_nxt;
      fin_flen_r    <= fin_flen_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_PREFETCH_SIZE: prefetch_size_r <= cfg_data;
          CFG_LOW_WATER:     low_water_r     <= cfg_data;
          default: begin
          end
        endcase
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result buffer and output payload registers.
  always_ff @(posedge clk) begin
    if (buf_we) begin
      buf_start_r[buf_widx] <= buf_wstart;
      buf_len_r[buf_widx]   <= buf_wlen;
    end
    if (out_load) begin
      out_grant_start_r  <= buf_start_r[drain_idx_r];
      out_grant_length_r <= buf_len_r[drain_idx_r];
      out_last_piece_r   <= is_last;
      out_fetch_launch_r <= is_last && fin_launch_r;
      out_fetch_length_r <= is_last ? fin_flen_r : '0;
      out_status_r       <= fin_status_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_grant_start  = out_grant_start_r;
  assign out_grant_length = out_grant_length_r;
  assign out_last_piece   = out_last_piece_r;
  assign out_fetch_launch = out_fetch_launch_r;
  assign out_fetch_length = out_fetch_length_r;
  assign out_status       = out_status_r;

  `IDRPD_ASSERT_ALWAYS(a_count_bound, clk, rst_n, entry_count_r <= QCNT_W'(QUEUE_DEPTH))
  `IDRPD_ASSERT_IMPL(a_pending_has_fetch, clk, rst_n,
                     (state_r == S_IDLE) && (pending_r != '0), fetch_busy_r)
  `IDRPD_ASSERT_IMPL(a_empty_no_volume, clk, rst_n,
                     (state_r == S_IDLE) && (entry_count_r == '0), held_volume_r == '0)
  `IDRPD_ASSERT_NEXT(a_last_ends_item, clk, rst_n, out_load && is_last,
                     (state_r == S_IDLE) && out_valid_r && out_last_piece_r)

endmodule
